/* src/tsl_pkg.sv */
// Package for the triangle strip to list converter: index width, stream widths,
// and the item and triangle types shared by the stages.
// No dependencies.
package tsl_pkg;

    localparam int INDEX_WIDTH = 15;

    // stream widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((INDEX_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((3 * INDEX_WIDTH + 7) / 8) * 8;

    typedef logic [INDEX_WIDTH-1:0] index_t;

    typedef struct packed {
        logic   restart;
        index_t vertex_index;
    } strip_item_t;

    typedef struct packed {
        index_t corner_c;
        index_t corner_b;
        index_t corner_a;
    } triangle_t;

    // handshake between the assembler and the output register
    typedef struct packed {
        logic   emit;
        logic   take;
    } asm_ctrl_t;

endpackage

/* src/triangle_strip_to_list.sv */
// Triangle strip to triangle list converter. Takes one strip index per
// transfer (tuser high starts a new strip) and emits one triangle per index
// from the third of a strip on, as (older, newer, new) at even positions and
// (newer, older, new) at odd ones; triangles with two equal corners are
// dropped but still advance the window. One index is taken every cycle: it
// passes an input register, the window logic and an output register on the
// way to its triangle. Throughput drops only while the downstream side holds
// a triangle back.
// Depends on tsl_pkg, tsl_in_stage, tsl_assemble, tsl_out_stage.
module triangle_strip_to_list (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tsl_pkg::S_TDATA_W-1:0]   s_tdata,  // vertex_index
    input  logic                            s_tuser,  // restart
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tsl_pkg::M_TDATA_W-1:0]   m_tdata   // corner_a, corner_b, corner_c
);
    import tsl_pkg::*;

    strip_item_t s_item;
    strip_item_t item;
    logic        item_valid;
    asm_ctrl_t   ctrl;
    triangle_t   tri_new;
    triangle_t   tri_held;
    logic        out_ready;

    assign s_item.vertex_index = s_tdata[INDEX_WIDTH-1:0];
    assign s_item.restart      = s_tuser;

    tsl_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (ctrl.take),
        .item_valid (item_valid),
        .item       (item)
    );

    tsl_assemble u_asm (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .ctrl       (ctrl),
        .tri_out    (tri_new)
    );

    tsl_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (ctrl.emit && ctrl.take),
        .tri_in   (tri_new),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .tri_out  (tri_held)
    );

    assign m_tdata = M_TDATA_W'(tri_held);

    // a shown triangle never has two equal corners
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (tri_held.corner_a != tri_held.corner_b)
                  && (tri_held.corner_b != tri_held.corner_c)
                  && (tri_held.corner_a != tri_held.corner_c))
    else $error("degenerate triangle on output");

    // a restart index never closes a triangle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item.restart) |-> !ctrl.emit)
    else $error("triangle formed on restart");

    // the newest corner of a pushed triangle is the index just consumed
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit && ctrl.take) |=> m_tvalid
                                  && (tri_held.corner_c == $past(item.vertex_index)))
    else $error("pushed triangle lost or wrong newest corner");

    // an item waits in the input register only when a triangle is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !ctrl.take) |-> ctrl.emit && m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

endmodule

/* src/tsl_in_stage.sv */
// Input register of the strip converter: holds one strip index transfer.
// Depends on tsl_pkg.
module tsl_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tsl_pkg::strip_item_t s_item,
    input  logic                 take,
    output logic                 item_valid,
    output tsl_pkg::strip_item_t item
);
    import tsl_pkg::*;

    logic        valid_reg;
    strip_item_t item_reg;

    // a held item leaving this cycle frees the slot for the next transfer
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

/* src/tsl_assemble.sv */
// Strip window and triangle formation: keeps the two held indices and the
// strip phase, builds one triangle per index from the third on.
// Depends on tsl_pkg.
module tsl_assemble (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  tsl_pkg::strip_item_t item,
    input  logic                 out_ready,
    output tsl_pkg::asm_ctrl_t   ctrl,
    output tsl_pkg::triangle_t   tri_out
);
    import tsl_pkg::*;

    typedef enum logic [1:0] {
        PH_EMPTY,
        PH_ONE,
        PH_EVEN,
        PH_ODD
    } phase_t;

    phase_t phase_reg, phase_next;
    index_t older_reg, older_next;
    index_t newer_reg, newer_next;

    logic start;
    logic form;
    logic distinct;
    logic emit;
    logic take;

    assign start    = item.restart || (phase_reg == PH_EMPTY);
    assign form     = !start && (phase_reg == PH_EVEN || phase_reg == PH_ODD);
    assign distinct = (older_reg != newer_reg) && (newer_reg != item.vertex_index)
                   && (older_reg != item.vertex_index);
    assign emit     = item_valid && form && distinct;
    // a triangle waits for room at the output; everything else goes straight through
    assign take     = item_valid && (!emit || out_ready);

    assign ctrl.emit = emit;
    assign ctrl.take = take;

    // odd positions swap the held pair to keep the winding
    always_comb
    begin
        if (phase_reg == PH_ODD)
        begin
            tri_out.corner_a = newer_reg;
            tri_out.corner_b = older_reg;
        end
        else
        begin
            tri_out.corner_a = older_reg;
            tri_out.corner_b = newer_reg;
        end
        tri_out.corner_c = item.vertex_index;
    end

    always_comb
    begin
        phase_next = phase_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        if (start)
        begin
            older_next = item.vertex_index;
            phase_next = PH_ONE;
        end
        else
        begin
            case (phase_reg)
                PH_ONE:
                begin
                    newer_next = item.vertex_index;
                    phase_next = PH_EVEN;
                end
                PH_EVEN:
                begin
                    older_next = newer_reg;
                    newer_next = item.vertex_index;
                    phase_next = PH_ODD;
                end
                PH_ODD:
                begin
                    older_next = newer_reg;
                    newer_next = item.vertex_index;
                    phase_next = PH_EVEN;
                end
                default:
                begin
                    phase_next = PH_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_EMPTY;
            older_reg <= '0;
            newer_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
        end
    end

endmodule

/* src/tsl_out_stage.sv */
// Output register of the strip converter: holds one triangle until the
// downstream side takes it.
// Depends on tsl_pkg.
module tsl_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tsl_pkg::triangle_t  tri_in,
    output logic                ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tsl_pkg::triangle_t  tri_out
);
    import tsl_pkg::*;

    logic      valid_reg;
    triangle_t tri_reg;

    assign ready    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign tri_out  = tri_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && ready)
        begin
            tri_reg <= tri_in;
        end
    end

endmodule
